[sv/sds_pkg.sv]
// Shared types and constants for the SCAN disk scheduler.
package sds_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MAX_REQUESTS_DEF = 32;
  localparam int unsigned CYL_BITS_DEF     = 8;

  // Fixed field widths of the transaction ports
  localparam int unsigned CYL_W     = 8;
  localparam int unsigned SEEK_W    = 9;
  localparam int unsigned AVG_W     = 17;
  localparam int unsigned FRAC_BITS = 8;

  // Input transaction kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_STEP,
    ST_DECIDE,
    ST_DIV
  } sds_state_e;

endpackage

[sv/sds_div.sv]
// Restoring divider, one quotient bit per cycle.
module sds_div import sds_pkg::*; #(
  parameter int unsigned DIV_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AVG_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [AVG_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(AVG_W + 1);

  // Partial remainder always stays below the divisor
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [AVG_W-1:0]  dvd_q, dvd_d;
  logic [DIV_W-1:0]  dsr_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q;
  logic              done_q;
  logic [DIV_W:0]    shifted;
  logic              fits;

  always_comb begin
    shifted = {rem_q, dvd_q[AVG_W-1]};
    fits    = (shifted >= {1'b0, dsr_q});
    rem_d   = fits ? DIV_W'(shifted - {1'b0, dsr_q}) : shifted[DIV_W-1:0];
    dvd_d   = {dvd_q[AVG_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(AVG_W);
      end else if (run_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

[sv/scan_disk_scheduler_core.sv]
// Top level of the SCAN (elevator) disk scheduler.
//
// Usage:
// - One input channel in command style: a transaction is taken at a rising edge
//   with start high and busy low. kind_i = 0 loads request_cylinder_i into the
//   request store (ignored once the store holds MAX_REQUESTS entries); kind_i = 1
//   starts a schedule from head_position_i and empties the store.
// - A load leaves busy low, so loads can follow every cycle.
// - A start with n requests raises busy and emits n + 1 results (requests at or
//   below the head descending, the turnaround at cylinder 0, then the rest
//   ascending), each on the result ports for one cycle with out_valid_o high.
// - Each result costs one selection pass: the single store read port scans all
//   n entries while the selection compare tracks the best unused candidate.
//   The last result also waits for the average seek from a bit-serial divider
//   (17 quotient bits, then the done flag). Busy is low again while the last
//   result shows.
// - A start on an empty store answers in the next cycle with a single error result.
// - The receiver cannot stall: results are never held back.
// - Reset clears the request count and the sequencer; the store holds no reset.
module scan_disk_scheduler_core import sds_pkg::*; #(
  parameter int unsigned MAX_REQUESTS = MAX_REQUESTS_DEF,
  parameter int unsigned CYL_BITS     = CYL_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             kind_i,
  input  logic [CYL_W-1:0] request_cylinder_i,
  input  logic [CYL_W-1:0] head_position_i,
  output logic             out_valid_o,
  output logic [CYL_W-1:0] service_cylinder_o,
  output logic [SEEK_W-1:0] running_seek_o,
  output logic             is_sweep_end_o,
  output logic [AVG_W-1:0] average_seek_o,
  output logic             is_last_o,
  output logic             error_o
);

  // Stored cylinder width: masked to CYL_BITS, never wider than the port
  localparam int unsigned SW    = (CYL_BITS < CYL_W) ? CYL_BITS : CYL_W;
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

  sds_state_e state_q, state_d;

  // Request store, one write port (loads) and one registered read port (scans)
  logic [SW-1:0] mem_q [MAX_REQUESTS];

  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        n_q;
  logic [CNT_W-1:0]        emitted_q;
  logic [IDX_W-1:0]        scan_idx_q;
  logic [MAX_REQUESTS-1:0] used_q;
  logic                    high_q;
  logic                    found_q;
  logic                    rd_vld_q;
  logic [SW-1:0]           rd_data_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic [SW-1:0]           best_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic [SW-1:0]           head_q;
  logic [SW-1:0]           pos_q;
  logic [SEEK_W-1:0]       total_q;
  logic [SW-1:0]           pend_cyl_q;
  logic                    pend_sweep_q;

  // Output register
  logic              out_valid_q;
  logic [CYL_W-1:0]  out_cyl_q;
  logic [SEEK_W-1:0] out_seek_q;
  logic              out_sweep_q;
  logic [AVG_W-1:0]  out_avg_q;
  logic              out_last_q;
  logic              out_err_q;

  logic              accept;
  logic              load_acc;
  logic              start_acc;
  logic              scan_last;
  logic              cand;
  logic              better;
  logic [SW-1:0]     delta;
  logic [SEEK_W-1:0] new_total;
  logic              sched_last;
  logic              div_start;
  logic              div_done;
  logic [AVG_W-1:0]  div_quot;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign load_acc  = accept && (kind_i == KIND_LOAD);
  assign start_acc = accept && (kind_i == KIND_START);

  // Selection compare on the word coming out of the store
  always_comb begin
    cand   = !used_q[rd_idx_q] && (high_q ? (rd_data_q > head_q) : (rd_data_q <= head_q));
    better = !found_q || (high_q ? (rd_data_q < best_q) : (rd_data_q > best_q));
  end

  // Seek step: toward the chosen request, or down to cylinder 0 at the turnaround
  always_comb begin
    if (!found_q) begin
      delta = pos_q;
    end else if (high_q) begin
      delta = best_q - pos_q;
    end else begin
      delta = pos_q - best_q;
    end
    new_total = total_q + SEEK_W'(delta);
    // Turnaround is last when every request was at or below the head;
    // otherwise the final upward visit is last.
    if (!found_q) begin
      sched_last = (emitted_q == n_q);
    end else begin
      sched_last = high_q && ((emitted_q + CNT_W'(1)) == n_q);
    end
    scan_last = (CNT_W'(scan_idx_q) == (n_q - CNT_W'(1)));
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_acc && (count_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sched_last) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      n_q         <= '0;
      emitted_q   <= '0;
      scan_idx_q  <= '0;
      used_q      <= '0;
      high_q      <= 1'b0;
      found_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      rd_vld_q    <= (state_q == ST_SCAN);
      if (load_acc && (count_q < CNT_W'(MAX_REQUESTS))) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (start_acc) begin
        count_q    <= '0;
        n_q        <= count_q;
        emitted_q  <= '0;
        scan_idx_q <= '0;
        used_q     <= '0;
        high_q     <= 1'b0;
        found_q    <= 1'b0;
        if (count_q == '0) begin
          out_valid_q <= 1'b1;
        end
      end
      if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (rd_vld_q && cand && better) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_DECIDE) begin
        found_q    <= 1'b0;
        scan_idx_q <= '0;
        if (found_q) begin
          used_q[best_idx_q] <= 1'b1;
          emitted_q          <= emitted_q + CNT_W'(1);
        end else begin
          high_q <= 1'b1;
        end
        if (!sched_last) begin
          out_valid_q <= 1'b1;
        end
      end
      if ((state_q == ST_DIV) && div_done) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (load_acc && (count_q < CNT_W'(MAX_REQUESTS))) begin
      mem_q[count_q[IDX_W-1:0]] <= request_cylinder_i[SW-1:0];
    end
    if (state_q == ST_SCAN) begin
      rd_data_q <= mem_q[scan_idx_q];
      rd_idx_q  <= scan_idx_q;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && cand && better) begin
      best_q     <= rd_data_q;
      best_idx_q <= rd_idx_q;
    end
    if (start_acc) begin
      head_q      <= head_position_i[SW-1:0];
      pos_q       <= head_position_i[SW-1:0];
      total_q     <= '0;
      out_cyl_q   <= '0;
      out_seek_q  <= '0;
      out_sweep_q <= 1'b0;
      out_avg_q   <= '0;
      out_last_q  <= 1'b1;
      out_err_q   <= 1'b1;
    end
    if (state_q == ST_DECIDE) begin
      total_q      <= new_total;
      pos_q        <= found_q ? best_q : '0;
      pend_cyl_q   <= found_q ? best_q : '0;
      pend_sweep_q <= !found_q;
      out_cyl_q    <= CYL_W'(found_q ? best_q : '0);
      out_seek_q   <= new_total;
      out_sweep_q  <= !found_q;
      out_avg_q    <= '0;
      out_last_q   <= 1'b0;
      out_err_q    <= 1'b0;
    end
    if ((state_q == ST_DIV) && div_done) begin
      out_cyl_q   <= CYL_W'(pend_cyl_q);
      out_seek_q  <= total_q;
      out_sweep_q <= pend_sweep_q;
      out_avg_q   <= div_quot;
      out_last_q  <= 1'b1;
      out_err_q   <= 1'b0;
    end
  end

  // Average seek: total with 8 fraction bits over the request count
  sds_div #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({new_total, {FRAC_BITS{1'b0}}}),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign out_valid_o        = out_valid_q;
  assign service_cylinder_o = out_cyl_q;
  assign running_seek_o     = out_seek_q;
  assign is_sweep_end_o     = out_sweep_q;
  assign average_seek_o     = out_avg_q;
  assign is_last_o          = out_last_q;
  assign error_o            = out_err_q;

endmodule

[sv/sds_checker.sv]
// Port-level checks for the SCAN disk scheduler, bound to the top level.
module sds_checker import sds_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              kind_i,
  input logic              out_valid_o,
  input logic [CYL_W-1:0]  service_cylinder_o,
  input logic [SEEK_W-1:0] running_seek_o,
  input logic [AVG_W-1:0]  average_seek_o,
  input logic              is_last_o,
  input logic              error_o
);

  // An error transaction is a one-result schedule
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> is_last_o)
    else $error("error result without is_last");

  // Only the final result carries an average
  a_avg_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_last_o |-> average_seek_o == '0)
    else $error("average on a non-final result");

  // Sequencer is free again once the final result shows
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_last_o |-> !busy)
    else $error("busy while final result shows");

  // A load produces no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (kind_i == KIND_LOAD) |=> !out_valid_o)
    else $error("result after a load");

  // Error results carry no position or seek
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (service_cylinder_o == '0) && (running_seek_o == '0))
    else $error("error result with payload");

endmodule

bind scan_disk_scheduler_core sds_checker u_sds_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .start              (start),
  .busy               (busy),
  .kind_i             (kind_i),
  .out_valid_o        (out_valid_o),
  .service_cylinder_o (service_cylinder_o),
  .running_seek_o     (running_seek_o),
  .average_seek_o     (average_seek_o),
  .is_last_o          (is_last_o),
  .error_o            (error_o)
);
